>>> rtl/cds_pkg.sv
package cds_pkg;

  // Action codes carried by a request
  localparam logic [2:0] ACT_DAY_NEXT = 3'd0;
  localparam logic [2:0] ACT_DAY_PREV = 3'd1;
  localparam logic [2:0] ACT_MON_NEXT = 3'd2;
  localparam logic [2:0] ACT_MON_PREV = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;
  localparam logic [2:0] ACT_LOAD     = 3'd5;

  // Calendar and clock limits
  localparam logic [7:0] YEAR_LAST   = 8'd179;
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [4:0] DAY_FIRST   = 5'd1;
  localparam logic [4:0] LEN_SHORT   = 5'd30;
  localparam logic [4:0] LEN_LONG    = 5'd31;
  localparam logic [4:0] LEN_FEB     = 5'd28;
  localparam logic [2:0] WDAY_LAST   = 3'd6;
  localparam logic [5:0] SEC_LAST    = 6'd59;
  localparam logic [5:0] MIN_LAST    = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [4:0] WEEK_LEN    = 5'd7;
  // Year offset whose low bits mark a leap year (1910 + offset divisible by 4)
  localparam logic [1:0] LEAP_PHASE  = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [2:0] load_weekday;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } req_t;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } res_t;

  // Days in a month; codes outside 1..12 count as long months
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = LEN_FEB + {4'd0, leap};
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = LEN_SHORT;
    end else begin
      len = LEN_LONG;
    end
    return len;
  endfunction

endpackage

>>> rtl/calendar_date_stepper_core.sv
// Channel | Ports                          | Carries
// in      | in_valid, in_ready, in_req     | one action request (req_t)
// out     | out_valid, out_ready, out_res  | date and time after the step (res_t)
//
// A request is captured in an input register and then stepped into the
// date/time register, which is also the result register.
// One request per cycle is sustained while results are taken each cycle.
// When the result is stalled the input register still takes one more request.
// rst_n (synchronous) resets the date to offset 0, month 1, day 1, weekday 0,
// time 00:00:00, and empties both registers.
module calendar_date_stepper_core import cds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic req_valid_r;
  req_t req_r;
  logic out_valid_r;
  res_t state_r;
  res_t state_nxt;
  logic adv;

  // Advance when a request waits and the result slot is free or being taken
  assign adv      = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || adv;

  cds_step u_step (
    .req (req_r),
    .cur (state_r),
    .nxt (state_nxt)
  );

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  // Update the date/time and present it as the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      state_r.year    <= 8'd0;
      state_r.month   <= MONTH_FIRST;
      state_r.day     <= DAY_FIRST;
      state_r.weekday <= 3'd0;
      state_r.hour    <= 5'd0;
      state_r.minute  <= 6'd0;
      state_r.second  <= 6'd0;
    end else begin
      if (adv) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = state_r;

  // A stalled result leaves the date/time untouched
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(state_r))
    else $error("date/time changed while result stalled");

  // A waiting request that cannot advance blocks the input
  a_block_in: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !adv) |-> !in_ready)
    else $error("input accepted over a waiting request");

  // Every advance yields a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advance without result");

  // A tick below the last second touches only the seconds
  a_tick_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req_r.action == ACT_TICK && state_r.second < SEC_LAST) |=>
      (state_r.second == $past(state_r.second) + 6'd1 &&
       $stable(state_r.minute) && $stable(state_r.day)))
    else $error("tick disturbed fields beyond seconds");

endmodule

>>> rtl/cds_step.sv
module cds_step import cds_pkg::*; (
  input  req_t req,
  input  res_t cur,
  output res_t nxt
);

  logic       leap;
  logic [4:0] len_cur;
  logic [7:0] year_inc;
  logic [7:0] year_dec;
  logic [3:0] mon_inc;
  logic [3:0] mon_dec;
  logic       wrap_fwd;
  logic       wrap_bwd;
  logic [4:0] len_inc;
  logic [4:0] len_dec;
  logic       back;
  logic [3:0] ms_mon;
  logic [4:0] ms_len;
  logic [4:0] ms_off;
  logic [4:0] ms_clamp;
  logic [4:0] ms_sum;
  logic [2:0] ms_wday;
  logic [4:0] ms_day;
  logic [7:0] ms_year;

  // Shared year and month neighbours
  always_comb begin
    leap     = (cur.year[1:0] == LEAP_PHASE);
    len_cur  = month_len(cur.month, leap);
    year_inc = (cur.year >= YEAR_LAST) ? 8'd0 : cur.year + 8'd1;
    year_dec = (cur.year == 8'd0 || cur.year > YEAR_LAST) ? YEAR_LAST : cur.year - 8'd1;
    wrap_fwd = (cur.month >= MONTH_LAST);
    wrap_bwd = (cur.month <= MONTH_FIRST);
    mon_inc  = wrap_fwd ? MONTH_FIRST : cur.month + 4'd1;
    mon_dec  = (wrap_bwd || cur.month > MONTH_LAST) ? MONTH_LAST : cur.month - 4'd1;
    len_inc  = month_len(mon_inc, leap);
    len_dec  = month_len(mon_dec, leap);
  end

  // Month step: weekday shift by month length mod 7, then day clamp
  always_comb begin
    back    = (req.action == ACT_MON_PREV);
    ms_mon  = back ? mon_dec : mon_inc;
    ms_len  = back ? len_dec : len_inc;
    ms_year = back ? (wrap_bwd ? year_dec : cur.year) : (wrap_fwd ? year_inc : cur.year);
    // month length mod 7 is its excess over 28
    ms_off  = back ? WEEK_LEN - (len_dec - LEN_FEB) : len_cur - LEN_FEB;
    if (cur.day > ms_len) begin
      ms_clamp = WEEK_LEN - (cur.day - ms_len);
      ms_day   = ms_len;
    end else begin
      ms_clamp = 5'd0;
      ms_day   = cur.day;
    end
    ms_sum = {2'd0, cur.weekday} + ms_off + ms_clamp;
    if (ms_sum >= 5'd14) begin
      ms_sum = ms_sum - 5'd14;
    end else if (ms_sum >= WEEK_LEN) begin
      ms_sum = ms_sum - WEEK_LEN;
    end
    ms_wday = ms_sum[2:0];
  end

  // Select the action
  always_comb begin
    nxt = cur;
    case (req.action)
      ACT_DAY_NEXT: begin
        if (cur.day >= len_cur) begin
          nxt.day   = DAY_FIRST;
          nxt.month = mon_inc;
          nxt.year  = wrap_fwd ? year_inc : cur.year;
        end else begin
          nxt.day = cur.day + 5'd1;
        end
        nxt.weekday = (cur.weekday >= WDAY_LAST) ? 3'd0 : cur.weekday + 3'd1;
      end
      ACT_DAY_PREV: begin
        if (cur.day <= DAY_FIRST) begin
          nxt.day   = len_dec;
          nxt.month = mon_dec;
          nxt.year  = wrap_bwd ? year_dec : cur.year;
        end else begin
          nxt.day = cur.day - 5'd1;
        end
        nxt.weekday = (cur.weekday == 3'd0) ? WDAY_LAST : cur.weekday - 3'd1;
      end
      ACT_MON_NEXT, ACT_MON_PREV: begin
        nxt.month   = ms_mon;
        nxt.day     = ms_day;
        nxt.weekday = ms_wday;
        nxt.year    = ms_year;
      end
      ACT_TICK: begin
        if (cur.second >= SEC_LAST) begin
          nxt.second = 6'd0;
          if (cur.minute >= MIN_LAST) begin
            nxt.minute = 6'd0;
            nxt.hour   = (cur.hour >= HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
          end else begin
            nxt.minute = cur.minute + 6'd1;
          end
        end else begin
          nxt.second = cur.second + 6'd1;
        end
      end
      ACT_LOAD: begin
        nxt.year    = req.load_year;
        nxt.month   = req.load_month;
        nxt.day     = req.load_day;
        nxt.weekday = req.load_weekday;
        nxt.hour    = req.load_hour;
        nxt.minute  = req.load_minute;
        nxt.second  = req.load_second;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  import cds_pkg::*;

  // Action codes the block leaves unused
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 425;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int PRINT_CAP        = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;

  req_t reqs_queued[$];   // requests waiting to be driven
  res_t dates_due[$];     // predicted date/time per accepted request
  res_t cal;              // predicted calendar state
  res_t due_now;
  bit   req_taken = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   err_count = 0;
  int   cycle_count = 0;

  calendar_date_stepper_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  initial forever #6 clk = ~clk;

  // Calendar arithmetic
  function automatic int leap_flag(logic [7:0] y);
    return ((int'(y) + 2) % 4 == 0) ? 1 : 0;
  endfunction

  function automatic int days_in(int m, int lp);
    if (m == MONTH_FEB) return LEN_FEB + lp;
    if (m == 4 || m == 6 || m == 9 || m == 11) return LEN_SHORT;
    return LEN_LONG;
  endfunction

  function automatic logic [7:0] year_moved(logic [7:0] y, bit back);
    if (!back) return (y >= YEAR_LAST) ? 8'd0 : y + 8'd1;
    return (y == 8'd0 || y > YEAR_LAST) ? YEAR_LAST : y - 8'd1;
  endfunction

  // Step the month; returns whether it crossed into another year
  function automatic bit shift_month(bit back, bit fix_wday);
    int lp, old, wk, len, nm;
    bit wrap;
    lp = leap_flag(cal.year);
    old = cal.month;
    wk = cal.weekday;
    wrap = 1'b0;
    if (!back) begin
      if (old >= MONTH_LAST) begin
        nm = MONTH_FIRST;
        wrap = 1'b1;
      end else begin
        nm = old + 1;
      end
      // add the length of the month left
      wk += days_in((nm == MONTH_FIRST) ? MONTH_LAST : nm - 1, lp) % WEEK_LEN;
    end else begin
      if (old <= MONTH_FIRST) begin
        nm = MONTH_LAST;
        wrap = 1'b1;
      end else if (old > MONTH_LAST) begin
        nm = MONTH_LAST;
      end else begin
        nm = old - 1;
      end
      // subtract the length of the month entered
      wk += WEEK_LEN - days_in(nm, lp) % WEEK_LEN;
    end
    // clamp the day and drop the weekday by the days removed
    len = days_in(nm, lp);
    if (cal.day > len) begin
      wk += WEEK_LEN - (int'(cal.day) - len) % WEEK_LEN;
      cal.day = 5'(len);
    end
    cal.month = 4'(nm);
    if (fix_wday) cal.weekday = 3'(wk % WEEK_LEN);
    return wrap;
  endfunction

  function automatic void shift_day(bit back);
    int lp, prev_m;
    bit over;
    lp = leap_flag(cal.year);
    over = 1'b0;
    if (!back) begin
      if (cal.day >= days_in(cal.month, lp)) begin
        cal.day = DAY_FIRST;
        over = 1'b1;
      end else begin
        cal.day = cal.day + 5'd1;
      end
      cal.weekday = (cal.weekday >= WDAY_LAST) ? 3'd0 : cal.weekday + 3'd1;
    end else begin
      if (cal.day <= DAY_FIRST) begin
        prev_m = (cal.month <= MONTH_FIRST || cal.month > MONTH_LAST) ?
                 MONTH_LAST : cal.month - 1;
        cal.day = 5'(days_in(prev_m, lp));
        over = 1'b1;
      end else begin
        cal.day = cal.day - 5'd1;
      end
      cal.weekday = (cal.weekday == 3'd0) ? WDAY_LAST : cal.weekday - 3'd1;
    end
    if (over && shift_month(back, 1'b0)) cal.year = year_moved(cal.year, back);
  endfunction

  function automatic void tick_clock();
    if (cal.second >= SEC_LAST) begin
      cal.second = '0;
      if (cal.minute >= MIN_LAST) begin
        cal.minute = '0;
        cal.hour = (cal.hour >= HOUR_LAST) ? 5'd0 : cal.hour + 5'd1;
      end else begin
        cal.minute = cal.minute + 6'd1;
      end
    end else begin
      cal.second = cal.second + 6'd1;
    end
  endfunction

  // Apply one request to the predicted state and return the date/time after it
  function automatic res_t step_calendar(req_t r);
    case (r.action)
      ACT_DAY_NEXT: shift_day(1'b0);
      ACT_DAY_PREV: shift_day(1'b1);
      ACT_MON_NEXT: if (shift_month(1'b0, 1'b1)) cal.year = year_moved(cal.year, 1'b0);
      ACT_MON_PREV: if (shift_month(1'b1, 1'b1)) cal.year = year_moved(cal.year, 1'b1);
      ACT_TICK: tick_clock();
      ACT_LOAD: begin
        cal.year    = r.load_year;
        cal.month   = r.load_month;
        cal.day     = r.load_day;
        cal.weekday = r.load_weekday;
        cal.hour    = r.load_hour;
        cal.minute  = r.load_minute;
        cal.second  = r.load_second;
      end
      default: ;
    endcase
    return cal;
  endfunction

  // Request builders
  function automatic req_t plain_request(logic [2:0] act);
    req_t r;
    r = '0;
    r.action = act;
    return r;
  endfunction

  function automatic req_t load_of(int y, int m, int d, int w, int h, int mi, int s);
    req_t r;
    r.action       = ACT_LOAD;
    r.load_year    = 8'(y);
    r.load_month   = 4'(m);
    r.load_day     = 5'(d);
    r.load_weekday = 3'(w);
    r.load_hour    = 5'(h);
    r.load_minute  = 6'(mi);
    r.load_second  = 6'(s);
    return r;
  endfunction

  // Load a date, mostly near month, year and clock boundaries
  function automatic req_t random_load();
    int y, m, d, len;
    req_t r;
    case ($urandom_range(0, 3))
      0: y = 0;
      1: y = YEAR_LAST;
      2: y = $urandom_range(0, 3);
      default: y = $urandom_range(0, YEAR_LAST);
    endcase
    case ($urandom_range(0, 5))
      0: m = MONTH_FEB;
      1: m = MONTH_FIRST;
      2: m = MONTH_LAST;
      default: m = $urandom_range(MONTH_FIRST, MONTH_LAST);
    endcase
    len = days_in(m, leap_flag(y));
    d = $urandom_range(0, 1) ? len - $urandom_range(0, 2) : $urandom_range(1, len);
    if ($urandom_range(0, 1))
      r = load_of(y, m, d, $urandom_range(0, 6), HOUR_LAST, MIN_LAST, $urandom_range(50, 59));
    else
      r = load_of(y, m, d, $urandom_range(0, 6), $urandom_range(0, 23),
                  $urandom_range(0, 59), $urandom_range(0, 59));
    return r;
  endfunction

  function automatic req_t random_request();
    logic [63:0] noise;
    int p;
    req_t r;
    noise = {$urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    p = $urandom_range(0, 99);
    if (p < 7) r = random_load();
    else if (p < 9) r.action = ACT_LOAD;        // any bits, range ignored
    else if (p == 9) r.action = ACT_UNUSED_LO;
    else if (p == 10) r.action = ACT_UNUSED_HI;
    else if (p < 35) r.action = ACT_DAY_NEXT;
    else if (p < 55) r.action = ACT_DAY_PREV;
    else if (p < 67) r.action = ACT_MON_NEXT;
    else if (p < 79) r.action = ACT_MON_PREV;
    else r.action = ACT_TICK;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (err_count < PRINT_CAP) $display("mismatch @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s got %0d, wanted %0d", name, got, want));
  endtask

  // Hold the sender until every request has been answered; look at the
  // rising edge, where the driver never pops the queue
  task automatic wait_all_settled();
    while (reqs_queued.size() != 0 || in_valid || dates_due.size() != 0)
      @(posedge clk);
  endtask

  // Drive requests and the result stall at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || req_taken) begin
        if (reqs_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req <= reqs_queued.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check results against the oldest prediction, then predict the new request
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (dates_due.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        due_now = dates_due.pop_front();
        check_field("year", out_res.year, due_now.year);
        check_field("month", out_res.month, due_now.month);
        check_field("day", out_res.day, due_now.day);
        check_field("weekday", out_res.weekday, due_now.weekday);
        check_field("hour", out_res.hour, due_now.hour);
        check_field("minute", out_res.minute, due_now.minute);
        check_field("second", out_res.second, due_now.second);
      end
    end
    if (req_taken) dates_due.push_back(step_calendar(in_req));
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 79, 0, 10};
    stall_by_phase = '{0, 0, 79, 10};
    cal = '0;
    cal.month = MONTH_FIRST;
    cal.day = DAY_FIRST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: wraps, leap February, clamping, clock carry, odd loads
    reqs_queued.push_back(plain_request(ACT_DAY_PREV));   // back past the first year
    reqs_queued.push_back(load_of(2, 2, 28, 3, 23, 59, 58));
    reqs_queued.push_back(plain_request(ACT_DAY_NEXT));   // into the leap day
    reqs_queued.push_back(plain_request(ACT_DAY_NEXT));
    reqs_queued.push_back(plain_request(ACT_DAY_PREV));
    reqs_queued.push_back(load_of(2, 3, 31, 1, 0, 0, 0));
    reqs_queued.push_back(plain_request(ACT_MON_PREV));   // clamp into leap February
    reqs_queued.push_back(plain_request(ACT_MON_NEXT));
    reqs_queued.push_back(load_of(5, 7, 4, 2, 23, 59, 58));
    reqs_queued.push_back(plain_request(ACT_TICK));
    reqs_queued.push_back(plain_request(ACT_TICK));       // carry through to midnight
    reqs_queued.push_back(load_of(YEAR_LAST, 12, 31, 6, 23, 59, 59));
    reqs_queued.push_back(plain_request(ACT_DAY_NEXT));   // last year wraps to first
    reqs_queued.push_back(plain_request(ACT_MON_PREV));
    reqs_queued.push_back(plain_request(ACT_MON_NEXT));
    reqs_queued.push_back(plain_request(ACT_UNUSED_LO));
    reqs_queued.push_back(plain_request(ACT_UNUSED_HI));
    reqs_queued.push_back(load_of(255, 15, 31, 7, 31, 63, 63));
    reqs_queued.push_back(plain_request(ACT_TICK));
    reqs_queued.push_back(plain_request(ACT_DAY_NEXT));
    reqs_queued.push_back(plain_request(ACT_MON_PREV));
    reqs_queued.push_back(load_of(200, 0, 0, 7, 0, 0, 0));
    reqs_queued.push_back(plain_request(ACT_DAY_PREV));
    reqs_queued.push_back(load_of(3, 1, 31, 4, 12, 30, 30));
    reqs_queued.push_back(plain_request(ACT_MON_NEXT));   // clamp to a short February
    wait_all_settled();

    // Random requests under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (RANDOM_PER_PHASE) reqs_queued.push_back(random_request());
      wait_all_settled();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/cds_pkg.sv
rtl/cds_step.sv
rtl/calendar_date_stepper_core.sv
verif/tb_top.sv
